FILE: design/dbpm_pkg.sv
// Shared types and codes for the dot-bracket pair matcher.
// Used by the stack cell, the stack chain and the top level.
`default_nettype none

package dbpm_pkg;

  // Width of the 13-bit position, partner and loop_id output fields.
  localparam int unsigned FIELD_W = 13;

  // Result kinds.
  localparam logic [1:0] KIND_UNPAIRED = 2'd0;
  localparam logic [1:0] KIND_OPEN     = 2'd1;
  localparam logic [1:0] KIND_CLOSE    = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNMATCHED = 3'd1;
  localparam logic [2:0] ST_UNCLOSED  = 3'd2;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // Configuration register indexes.
  localparam logic REG_OPEN_CHAR  = 1'b0;
  localparam logic REG_CLOSE_CHAR = 1'b1;

  // Shift control for the stack chain.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  // One result item, last field (position) in the lowest bits.
  typedef struct packed {
    logic [2:0]         status;
    logic [FIELD_W-1:0] loop_id;
    logic [FIELD_W-1:0] partner;
    logic [1:0]         kind;
    logic [FIELD_W-1:0] position;
  } result_t;

endpackage

`default_nettype wire

FILE: design/dbpm_cell.sv
// One stack cell: holds a single stack entry and shifts with its neighbors.
// Depends on dbpm_pkg for the shift control struct.
`default_nettype none

module dbpm_cell
  import dbpm_pkg::*;
#(
  parameter int unsigned W = 26
) (
  input  wire logic        clk,
  input  wire stack_ctrl_t ctrl,
  input  wire logic [W-1:0] from_above,
  input  wire logic [W-1:0] from_below,
  output logic [W-1:0]     entry
);

  // A push moves entries away from the top, a pop moves them toward it.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= from_above;
    end else if (ctrl.pop) begin
      entry <= from_below;
    end
  end

endmodule

`default_nettype wire

FILE: design/dbpm_stack.sv
// Open-bracket stack built as a chain of shift cells, top entry in cell 0.
// Depends on dbpm_pkg and dbpm_cell.
`default_nettype none

module dbpm_stack
  import dbpm_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned W     = 26
) (
  input  wire logic        clk,
  input  wire stack_ctrl_t ctrl,
  input  wire logic [W-1:0] push_entry,
  output logic [W-1:0]     top_entry,
  output logic [W-1:0]     second_entry
);

  // Cell outputs; the slot past the bottom feeds zeros into the last cell.
  logic [W-1:0] node [DEPTH+1];

  assign node[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] above;
    if (i == 0) begin : g_top
      assign above = push_entry;
    end else begin : g_inner
      assign above = node[i-1];
    end
    dbpm_cell #(.W(W)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (node[i+1]),
      .entry      (node[i])
    );
  end

  assign top_entry    = node[0];
  assign second_entry = node[1];

endmodule

`default_nettype wire

FILE: design/dot_bracket_pair_matcher_unit.sv
// Top level of the dot-bracket pair matcher: counters, classification,
// output skid buffer. Depends on dbpm_pkg, dbpm_stack and dbpm_cell.
//
//  channel | dir | tdata bits (low first)                       | tlast
//  s_axis  | in  | ch[7:0]                                      | last
//  m_axis  | out | position, kind, partner, loop_id, status, pad | end_flag
//  cfg     | in  | cfg_index 0 open_char, 1 close_char           | -
//
// One character per cycle while s_tready is high: push, pop and the next
// loop id come straight from the top two cells of the shift-register stack
// in the same cycle. Each result is registered in the output buffer.
// A two-entry output buffer keeps input accepted while a result waits.
// rst is synchronous; stack cells are not cleared, only the height is.
`default_nettype none

module dot_bracket_pair_matcher_unit
  import dbpm_pkg::*;
#(
  parameter int unsigned MAX_LEN   = 4096,
  parameter int unsigned MAX_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream: tdata = ch[7:0].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  // Output stream: tdata = position[12:0], kind[14:13], partner[27:15],
  // loop_id[40:28], status[43:41], zero pad[47:44].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,
  output logic             m_tlast,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned HW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned EW = 2 * CW;
  localparam logic [CW-1:0] LEN_LIMIT   = CW'(MAX_LEN);
  localparam logic [HW-1:0] DEPTH_LIMIT = HW'(MAX_DEPTH);

  // Configuration registers.
  logic [7:0] open_char;
  logic [7:0] close_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_char  <= 8'd40;
      close_char <= 8'd41;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPEN_CHAR:  open_char  <= cfg_wdata;
        REG_CLOSE_CHAR: close_char <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // String state.
  logic [CW-1:0] char_count, char_count_next;
  logic [CW-1:0] loop_counter, loop_counter_next;
  logic [CW-1:0] current_loop, current_loop_next;
  logic [HW-1:0] stack_height, stack_height_next;

  logic          accept;
  logic          too_long, is_open, is_close, stack_full, stack_empty;
  logic [CW-1:0] pos_new, loop_new, loop_out, partner_out;
  logic [1:0]    kind_out;
  logic [2:0]    status_out;
  stack_ctrl_t   ctrl;
  logic [EW-1:0] top_entry, second_entry, push_entry;
  result_t       result;

  assign accept = s_tvalid && s_tready;

  dbpm_stack #(.DEPTH(MAX_DEPTH), .W(EW)) u_stack (
    .clk          (clk),
    .ctrl         (ctrl),
    .push_entry   (push_entry),
    .top_entry    (top_entry),
    .second_entry (second_entry)
  );

  // Classify the character and work out its result and the next state.
  always_comb begin
    too_long    = char_count >= LEN_LIMIT;
    is_open     = s_tdata == open_char;
    is_close    = !is_open && s_tdata == close_char;
    stack_full  = stack_height >= DEPTH_LIMIT;
    stack_empty = stack_height == '0;
    pos_new     = char_count + 1'b1;
    loop_new    = loop_counter + 1'b1;
    push_entry  = {loop_new, pos_new};

    ctrl.push = accept && !too_long && is_open && !stack_full;
    ctrl.pop  = accept && !too_long && is_close && !stack_empty;

    char_count_next   = char_count;
    loop_counter_next = loop_counter;
    current_loop_next = current_loop;
    stack_height_next = stack_height;
    kind_out    = KIND_UNPAIRED;
    partner_out = '0;
    loop_out    = '0;
    status_out  = ST_OK;

    if (too_long) begin
      status_out = ST_TOO_LONG;
    end else begin
      char_count_next = pos_new;
      loop_out        = current_loop;
      if (is_open) begin
        kind_out          = KIND_OPEN;
        loop_counter_next = loop_new;
        current_loop_next = loop_new;
        loop_out          = loop_new;
        if (stack_full) begin
          status_out = ST_TOO_DEEP;
        end else begin
          stack_height_next = stack_height + 1'b1;
        end
      end else if (is_close) begin
        kind_out = KIND_CLOSE;
        if (stack_empty) begin
          status_out = ST_UNMATCHED;
        end else begin
          stack_height_next = stack_height - 1'b1;
          partner_out       = top_entry[CW-1:0];
          current_loop_next = (stack_height > HW'(1)) ? second_entry[EW-1:CW] : '0;
        end
      end
    end

    if (s_tlast && status_out == ST_OK && stack_height_next != '0) begin
      status_out = ST_UNCLOSED;
    end

    result.position = too_long ? '0 : FIELD_W'(pos_new);
    result.kind     = kind_out;
    result.partner  = FIELD_W'({{FIELD_W{1'b0}}, partner_out});
    result.loop_id  = FIELD_W'({{FIELD_W{1'b0}}, loop_out});
    result.status   = status_out;
  end

  // State update; the last character returns the string state to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      loop_counter <= '0;
      current_loop <= '0;
      stack_height <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        char_count   <= '0;
        loop_counter <= '0;
        current_loop <= '0;
        stack_height <= '0;
      end else begin
        char_count   <= char_count_next;
        loop_counter <= loop_counter_next;
        current_loop <= current_loop_next;
        stack_height <= stack_height_next;
      end
    end
  end

  // Output register with one skid entry behind it.
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    out_last, skid_last;
  logic    drain;

  assign s_tready = !skid_valid;
  assign drain    = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_last <= skid_last;
      end else if (accept) begin
        out_data <= result;
        out_last <= s_tlast;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= result;
        skid_last <= s_tlast;
      end else begin
        out_data <= result;
        out_last <= s_tlast;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_data};
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  // The stack never shifts both ways in one cycle.
  a_no_push_pop : assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("stack push and pop in the same cycle");

  // The stack height stays within the cell chain.
  a_height_bound : assert property (@(posedge clk) disable iff (rst)
    stack_height <= DEPTH_LIMIT)
    else $error("stack height beyond depth");

  // A last character leaves the string state cleared.
  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> char_count == '0 && stack_height == '0
      && current_loop == '0)
    else $error("string state not cleared after last character");

  // The skid entry is only used behind a full output register.
  a_skid_order : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  // A pop that does not end the string lowers the height by one.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    ctrl.pop && !s_tlast |=> stack_height == $past(stack_height) - 1'b1)
    else $error("pop did not lower the stack height");
`endif

endmodule

`default_nettype wire
